/* sv/minst_pkg.sv */
// ----------------------------------------------------------------------------
// minst_pkg
// shared types and constants of the running-minimum stack
// ----------------------------------------------------------------------------
package minst_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int WORD_BITS_DEF = 32;

	// operation codes
	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_RESERVED  = 2'd3
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_FETCH = 2'd1,
		S_RESP  = 2'd2
	} state_t;

endpackage

/* sv/minst_ram.sv */
// ----------------------------------------------------------------------------
// minst_ram
// single-port-write, single-port-read synchronous ram, registered read data
// ----------------------------------------------------------------------------
module minst_ram #(
	parameter int DEPTH     = minst_pkg::DEPTH_DEF,
	parameter int WORD_BITS = minst_pkg::WORD_BITS_DEF,
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/stack_with_running_minimum_unit.sv */
// ----------------------------------------------------------------------------
// stack_with_running_minimum_unit
// a push or a rejected item answers from S_RESP, a pop goes through S_FETCH
// throughput: one push per cycle while busy is low; a pop holds busy in S_FETCH
// while the new top and minimum return from the two stores (one read port each)
// reset: arst_n clears the pointers and the controller; the stores keep
// garbage, which never reaches the ports since an empty stack reads as zero
// done is a one-cycle strobe; the receiver cannot stall results
// ----------------------------------------------------------------------------
module stack_with_running_minimum_unit #(
	parameter int DEPTH     = minst_pkg::DEPTH_DEF,
	parameter int WORD_BITS = minst_pkg::WORD_BITS_DEF,
	localparam int CW       = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command side
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic signed [WORD_BITS-1:0] value,
	// result side
	output logic                        done,
	output logic signed [WORD_BITS-1:0] top_value,
	output logic signed [WORD_BITS-1:0] min_value,
	output logic [CW-1:0]               entry_count,
	output logic [1:0]                  status
);

	import minst_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// architectural state: pointers plus cached tops of both stores
	state_t                      state_q, state_d;
	logic [CW-1:0]               ep_q;      // entries held
	logic [CW-1:0]               mp_q;      // minima held
	logic signed [WORD_BITS-1:0] top_q;     // copy of entry_store[ep-1]
	logic signed [WORD_BITS-1:0] min_q;     // copy of minimum_store[mp-1]
	status_t                     status_q;
	logic                        pop_min_q; // pop also dropped a minimum

	// decode of the incoming word
	logic accept;
	logic is_push, is_pop;
	logic full, empty;
	logic push_ok, pop_ok;
	logic add_min;
	logic pop_min;

	// store ports
	logic                 ent_we, min_we;
	logic                 rd_en;
	logic [CW-1:0]        ep_m2, mp_m2;
	logic [WORD_BITS-1:0] ent_rdata, min_rdata;

	// the last result may still be on the ports while a new word comes in
	assign accept  = start && !busy;
	assign is_push = (op_t'(req_type) == OP_PUSH);
	assign is_pop  = (op_t'(req_type) == OP_POP);
	assign full    = (ep_q == CW'(DEPTH));
	assign empty   = (ep_q == '0);
	assign push_ok = accept && is_push && !full;
	assign pop_ok  = accept && is_pop && !empty;

	// equal values join the chain too so duplicates pop correctly
	assign add_min = empty || (mp_q == '0) || (value <= min_q);
	// the chain always holds at least one minimum while entries exist
	assign pop_min = (mp_q != '0) && (top_q == min_q);

	// after a pop the new tops live one below the old ones
	assign ep_m2 = ep_q - CW'(2);
	assign mp_m2 = mp_q - CW'(2);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE, S_RESP: begin
				if (pop_ok) begin
					state_d = S_FETCH;
				end else if (accept) begin
					state_d = S_RESP;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FETCH: begin
				state_d = S_RESP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs of the controller
	always_comb begin
		busy   = 1'b0;
		done   = 1'b0;
		ent_we = 1'b0;
		min_we = 1'b0;
		rd_en  = 1'b0;
		unique case (state_q)
			S_IDLE, S_RESP: begin
				done   = (state_q == S_RESP);
				ent_we = push_ok;
				min_we = push_ok && add_min && (mp_q != CW'(DEPTH));
				rd_en  = pop_ok;
			end
			S_FETCH: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	minst_ram #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ep_q[AW-1:0]),
		.wdata (value),
		.re    (rd_en),
		.raddr (ep_m2[AW-1:0]),
		.rdata (ent_rdata)
	);

	minst_ram #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_min_ram (
		.clk   (clk),
		.we    (min_we),
		.waddr (mp_q[AW-1:0]),
		.wdata (value),
		.re    (rd_en),
		.raddr (mp_m2[AW-1:0]),
		.rdata (min_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ep_q    <= '0;
			mp_q    <= '0;
		end else begin
			state_q <= state_d;
			if (push_ok) begin
				ep_q <= ep_q + CW'(1);
				if (min_we) begin
					mp_q <= mp_q + CW'(1);
				end
			end else if (pop_ok) begin
				ep_q <= ep_q - CW'(1);
				if (pop_min) begin
					mp_q <= mp_q - CW'(1);
				end
			end
		end
	end

	// cached tops and result status
	always_ff @(posedge clk) begin
		if (accept) begin
			priority if (push_ok) begin
				status_q <= ST_DONE;
				top_q    <= value;
				if (min_we) begin
					min_q <= value;
				end
			end else if (pop_ok) begin
				status_q  <= ST_DONE;
				pop_min_q <= pop_min;
			end else if (is_push) begin
				status_q <= ST_FULL;
			end else begin
				status_q <= ST_EMPTY;
			end
		end
		// read data of the pop comes back here
		if (state_q == S_FETCH) begin
			top_q <= ent_rdata;
			if (pop_min_q) begin
				min_q <= min_rdata;
			end
		end
	end

	// empty stack reads as zero
	assign top_value   = empty ? '0 : top_q;
	assign min_value   = (empty || (mp_q == '0)) ? '0 : min_q;
	assign entry_count = ep_q;
	assign status      = status_q;

endmodule

/* sv/minst_checker.sv */
// ----------------------------------------------------------------------------
// minst_checker
// port-level checks of the running-minimum stack, bound to the top level
// ----------------------------------------------------------------------------
module minst_checker #(
	parameter int DEPTH     = minst_pkg::DEPTH_DEF,
	parameter int WORD_BITS = minst_pkg::WORD_BITS_DEF,
	localparam int CW       = $clog2(DEPTH + 1)
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        req_type,
	input logic                        done,
	input logic signed [WORD_BITS-1:0] top_value,
	input logic signed [WORD_BITS-1:0] min_value,
	input logic [CW-1:0]               entry_count,
	input logic [1:0]                  status
);

	import minst_pkg::*;

	// busy drops after the pop fetch, and the result follows in the next cycle
	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (!busy && done))
		else $error("busy held longer than one cycle");

	// every accepted word gives a result or a fetch cycle next
	a_accept_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted word produced no result");

	// a push never stalls
	a_push_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op_t'(req_type) == OP_PUSH)) |=> done)
		else $error("push result late");

	// overflow only on a full stack
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_t'(status) == ST_FULL)) |-> (entry_count == CW'(DEPTH)))
		else $error("overflow reported on a stack that is not full");

	// empty stack shows zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (entry_count == '0)) |-> ((top_value == '0) && (min_value == '0)))
		else $error("empty stack shows nonzero top or minimum");

endmodule

bind stack_with_running_minimum_unit minst_checker #(
	.DEPTH     (DEPTH),
	.WORD_BITS (WORD_BITS)
) u_minst_checker (.*);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the running-minimum stack: a shadow stack predicts
// top, minimum, count and status for every accepted word, and each done strobe
// is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import minst_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int WORD_BITS   = WORD_BITS_DEF;
	localparam int CW          = $clog2(DEPTH + 1);
	// cycles with nothing accepted on either side before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	// a pop reports only after its fetch state, so this covers any straggler
	localparam int DRAIN_TAIL  = 5;

	typedef logic signed [WORD_BITS-1:0] word_t;

	// one predicted result word
	typedef struct {
		word_t         top;
		word_t         low;
		logic [CW-1:0] count;
		status_t       status;
	} outcome_t;

	// shadow copy of the stack and its chain of minima
	class stack_shadow;
		word_t       entries [DEPTH];
		word_t       minima [DEPTH];
		int unsigned held;
		int unsigned minima_held;
		outcome_t    expected_outcomes [$];
		int unsigned mismatches;

		// apply one accepted word and queue the result it must produce
		function void note_word(op_t op, word_t val);
			outcome_t o;
			o.status = ST_DONE;
			if (op == OP_PUSH) begin
				if (held >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					// ties join the chain too, so popping a duplicate keeps the minimum
					if (held == 0 || minima_held == 0 || val <= minima[minima_held - 1]) begin
						if (minima_held < DEPTH) begin
							minima[minima_held] = val;
							minima_held++;
						end
					end
					entries[held] = val;
					held++;
				end
			end else begin
				if (held == 0) begin
					o.status = ST_EMPTY;
				end else begin
					if (minima_held > 0 && minima[minima_held - 1] == entries[held - 1])
						minima_held--;
					held--;
				end
			end
			o.top   = (held > 0) ? entries[held - 1] : '0;
			o.low   = (held > 0 && minima_held > 0) ? minima[minima_held - 1] : '0;
			o.count = held[CW-1:0];
			expected_outcomes.insert(expected_outcomes.size(), o);
		endfunction

		function void log_mismatch(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: %s", $realtime, what);
		endfunction

		// compare a result word with the oldest prediction
		function void check_word(word_t top, word_t low, logic [CW-1:0] count, status_t st);
			outcome_t want;
			if (expected_outcomes.size() == 0) begin
				log_mismatch($sformatf("unexpected result top %0d min %0d count %0d status %0d",
					top, low, count, st));
				return;
			end
			want = expected_outcomes[0];
			expected_outcomes.delete(0);
			if (want.top !== top || want.low !== low || want.count !== count ||
					want.status !== st)
				log_mismatch($sformatf({"expected top %0d min %0d count %0d status %0d, ",
					"got top %0d min %0d count %0d status %0d"},
					want.top, want.low, want.count, want.status, top, low, count, st));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and block inputs; every input is known from time zero
	// ------------------------------------------------------------------------
	logic          clk;
	logic          arst_n   = 1'b0;
	logic          start    = 1'b0;
	logic          req_type = OP_PUSH;
	word_t         value    = '0;
	logic          busy;
	logic          done;
	word_t         top_value;
	word_t         min_value;
	logic [CW-1:0] entry_count;
	logic [1:0]    status;

	stack_shadow   board;
	int unsigned   idle_pct;
	int unsigned   stall_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	stack_with_running_minimum_unit #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.value       (value),
		.done        (done),
		.top_value   (top_value),
		.min_value   (min_value),
		.entry_count (entry_count),
		.status      (status)
	);

	// ------------------------------------------------------------------------
	// monitor: everything is sampled at the edge, before the block updates
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			// a result always belongs to a word accepted at an earlier edge,
			// so check it before noting the word accepted at this edge
			if (done)
				board.check_word(top_value, min_value, entry_count, status_t'(status));
			if (start && !busy)
				board.note_word(op_t'(req_type), value);
		end
	end

	// watchdog: any accepted word or result restarts the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// driver
	// ------------------------------------------------------------------------

	// hold the word on the ports until an edge sees busy low, then idle for
	// each cycle that draws below idle_pct; when no idle follows, start simply
	// stays high for the next word
	task automatic issue_word(input op_t op, input word_t val);
		start    <= 1'b1;
		req_type <= op;
		value    <= val;
		@(posedge clk);
		while (busy) @(posedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start    <= 1'b0;
			// junk on the payload while start is low
			req_type <= 1'($urandom_range(0, 1));
			value    <= word_t'($urandom);
			@(posedge clk);
		end
	endtask

	// values mix wide random words, a narrow band that makes duplicates and ties
	// with the running minimum, and the extremes of the signed range
	function automatic word_t pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return word_t'($urandom);
			4, 5, 6:    return word_t'($urandom_range(0, 16)) - word_t'(8);
			7: begin
				case ($urandom_range(0, 3))
					0:       return {1'b0, {(WORD_BITS-1){1'b1}}};
					1:       return {1'b1, {(WORD_BITS-1){1'b0}}};
					2:       return '0;
					default: return '1;
				endcase
			end
			default:    return word_t'($urandom_range(0, 1000)) - word_t'(500);
		endcase
	endfunction

	// runs of mostly pushes, mostly pops or an even mix, so the stack keeps
	// swinging between empty and full and both rejections come up often
	task automatic run_phase(input int unsigned items);
		int unsigned sent;
		int unsigned run_len;
		int unsigned push_pct;
		sent = 0;
		while (sent < items) begin
			run_len = $urandom_range(4, 80);
			if (run_len > items - sent)
				run_len = items - sent;
			case ($urandom_range(0, 2))
				0:       push_pct = 90;
				1:       push_pct = 10;
				default: push_pct = 50;
			endcase
			repeat (run_len) begin
				if ($urandom_range(0, 99) < push_pct)
					issue_word(OP_PUSH, pick_value());
				else
					issue_word(OP_POP, word_t'($urandom));
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		board    = new;
		idle_pct = 16;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pop on an empty stack right after reset, and again after draining
		issue_word(OP_POP, '1);
		// equal values: the duplicate minimum must survive the first pop of it
		issue_word(OP_PUSH, word_t'(5));
		issue_word(OP_PUSH, word_t'(5));
		issue_word(OP_PUSH, word_t'(7));
		issue_word(OP_PUSH, word_t'(3));
		issue_word(OP_POP, '0);
		issue_word(OP_POP, '0);
		issue_word(OP_POP, '0);
		issue_word(OP_POP, '0);
		issue_word(OP_POP, {1'b1, {(WORD_BITS-1){1'b0}}});
		// extremes of the signed range, with a repeated most-negative minimum
		issue_word(OP_PUSH, {1'b0, {(WORD_BITS-1){1'b1}}});
		issue_word(OP_PUSH, {1'b1, {(WORD_BITS-1){1'b0}}});
		issue_word(OP_PUSH, '0);
		issue_word(OP_PUSH, '1);
		issue_word(OP_PUSH, {1'b1, {(WORD_BITS-1){1'b0}}});
		repeat (5) issue_word(OP_POP, word_t'($urandom));

		// sender idles often, then very often, then never
		run_phase(330);
		idle_pct = 65;
		run_phase(350);
		idle_pct = 0;
		run_phase(350);

		start <= 1'b0;
		while (board.expected_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		if (board.mismatches == 0 && board.expected_outcomes.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
